// ----- sv/rfa_pkg.sv -----
package rfa_pkg;

   localparam logic [15:0] MIN_ARRAY_OFFSET = 16'd42;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_BAD_HDR  = 3'd1;
   localparam logic [2:0] STATUS_MISMATCH = 3'd2;
   localparam logic [2:0] STATUS_SHORT    = 3'd3;
   localparam logic [2:0] STATUS_PAST_END = 3'd4;

   localparam logic CSR_OFFSET_POS = 1'b0;
   localparam logic CSR_COUNT_POS  = 1'b1;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] fixed_byte;
      logic       record_done;
      logic [2:0] fixup_status;
   } rfa_result_type;

   typedef struct packed {
      logic           lead_valid;
      logic           tail_valid;
      rfa_result_type lead;
      rfa_result_type tail;
   } rfa_push_type;

endpackage

// ----- sv/rfa_out_queue.sv -----
module rfa_out_queue
   import rfa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rfa_push_type   push,
   output logic           space,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rfa_result_type rsp_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rfa_result_type    entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  wr_next;
   logic              pop;
   logic [CNT_W-1:0]  push_n;

   assign pop       = (count_ff != '0) && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign space     = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + PTR_W'(1);
   assign push_n    = CNT_W'(push.lead_valid) + CNT_W'(push.lead_valid & push.tail_valid);

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      count_in  = count_ff + push_n - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.lead_valid) begin
         entry_ff[wr_ptr_ff] <= push.lead;
         if (push.tail_valid) begin
            entry_ff[wr_next] <= push.tail;
         end
      end
   end

endmodule

// ----- sv/rfa_fixup_core.sv -----
module rfa_fixup_core
   import rfa_pkg::*;
#(
   parameter int RECORD_BYTES = 1024,
   parameter int SECTOR_BYTES = 512
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  logic [7:0]   record_byte,
   input  logic         final_byte,
   input  logic [5:0]   offset_pos,
   input  logic [5:0]   count_pos,
   output rfa_push_type push
);

   localparam int POS_W  = $clog2(RECORD_BYTES + 1);
   localparam int SPOS_W = $clog2(SECTOR_BYTES);
   localparam int SLOTS  = RECORD_BYTES / SECTOR_BYTES + 1;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SPOS_W-1:0] sec_pos_ff, sec_pos_in;
   logic [IDX_W-1:0]  sec_idx_ff, sec_idx_in;
   logic [15:0]       off_ff, off_in;
   logic [15:0]       cnt_ff, cnt_in;
   logic [15:0]       seq_ff, seq_in;
   logic [15:0]       repl_ff [SLOTS];
   logic [15:0]       repl_in [SLOTS];
   logic [7:0]        held_ff, held_in;
   logic              hold_ff, hold_in;
   logic [2:0]        status_ff, status_in;
   logic              stopped_ff, stopped_in;
   logic              hdr_ok_ff, hdr_ok_in;

   logic              in_range;
   logic [6:0]        hl;
   logic              check, good;
   logic [15:0]       p16;
   logic [15:0]       rel;
   logic [14:0]       w;
   logic [IDX_W-1:0]  widx;
   logic [15:0]       pair;
   logic [15:0]       r;
   logic [15:0]       i16;
   logic [17:0]       entry_end;
   logic              lead_v, tail_v;
   logic [7:0]        lead_b, tail_b;

   always_comb begin
      in_range   = (pos_ff < POS_W'(RECORD_BYTES));
      p16        = 16'(pos_ff);
      hl         = ((offset_pos > count_pos) ? {1'b0, offset_pos} : {1'b0, count_pos}) + 7'd1;
      off_in     = off_ff;
      cnt_in     = cnt_ff;
      seq_in     = seq_ff;
      repl_in    = repl_ff;
      held_in    = held_ff;
      hold_in    = hold_ff;
      status_in  = status_ff;
      stopped_in = stopped_ff;
      hdr_ok_in  = hdr_ok_ff;
      rel        = '0;
      w          = '0;
      widx       = '0;
      pair       = {record_byte, held_ff};
      r          = '0;
      i16        = 16'(sec_idx_ff) + 16'd1;
      entry_end  = '0;
      check      = 1'b0;
      good       = 1'b0;
      lead_v     = 1'b1;
      tail_v     = 1'b0;
      lead_b     = record_byte;
      tail_b     = record_byte;

      if (in_range) begin
         // header field capture
         if (pos_ff == POS_W'(offset_pos)) off_in[7:0] = record_byte;
         if (pos_ff == POS_W'({1'b0, offset_pos} + 7'd1)) off_in[15:8] = record_byte;
         if (pos_ff == POS_W'(count_pos)) cnt_in[7:0] = record_byte;
         if (pos_ff == POS_W'({1'b0, count_pos} + 7'd1)) cnt_in[15:8] = record_byte;

         check = (pos_ff == POS_W'(hl)) && !hdr_ok_ff && (status_ff == STATUS_OK);
         good  = (off_in >= MIN_ARRAY_OFFSET) && (off_in < 16'(RECORD_BYTES)) &&
                 (cnt_in != 16'd0) &&
                 (({2'b00, off_in} + {1'b0, cnt_in, 1'b0}) <= 18'(RECORD_BYTES)) &&
                 (off_in > {9'd0, hl});
         if (check) begin
            if (good) begin
               hdr_ok_in = 1'b1;
            end else begin
               if (status_in == STATUS_OK) status_in = STATUS_BAD_HDR;
               stopped_in = 1'b1;
            end
         end

         // update array capture
         if (hdr_ok_in && (p16 >= off_in)) begin
            rel  = p16 - off_in;
            w    = rel[15:1];
            widx = IDX_W'(w - 15'd1);
            if ({1'b0, w} < cnt_in) begin
               if (w == 15'd0) begin
                  if (rel[0]) seq_in[15:8] = record_byte;
                  else seq_in[7:0] = record_byte;
               end else if (w < 15'(SLOTS)) begin
                  if (rel[0]) repl_in[widx][15:8] = record_byte;
                  else repl_in[widx][7:0] = record_byte;
               end
            end
         end

         r = repl_in[sec_idx_ff];
         entry_end = {2'b00, off_in} + {1'b0, i16, 1'b0} + 18'd1;

         if (hold_ff) begin
            hold_in = 1'b0;
            tail_v  = 1'b1;
            if ((pair == seq_in) && (i16 < 16'(SLOTS))) begin
               lead_b = r[7:0];
               tail_b = r[15:8];
            end else begin
               if (status_in == STATUS_OK) status_in = STATUS_MISMATCH;
               stopped_in = 1'b1;
               lead_b = held_ff;
               tail_b = record_byte;
            end
         end else if (hdr_ok_in && !stopped_in && !final_byte &&
                      (sec_pos_ff == SPOS_W'(SECTOR_BYTES - 2))) begin
            if (i16 < cnt_in) begin
               if (entry_end < 18'(pos_ff)) begin
                  held_in = record_byte;
                  hold_in = 1'b1;
                  lead_v  = 1'b0;
               end else begin
                  if (status_in == STATUS_OK) status_in = STATUS_PAST_END;
                  stopped_in = 1'b1;
               end
            end
         end
      end

      if (final_byte && (status_in == STATUS_OK)) begin
         if (pos_ff < POS_W'(RECORD_BYTES - 1)) status_in = STATUS_SHORT;
         else if (!hdr_ok_in) status_in = STATUS_BAD_HDR;
      end

      push.lead_valid        = take && lead_v;
      push.tail_valid        = take && tail_v;
      push.lead.fixed_byte   = lead_b;
      push.lead.record_done  = final_byte && !tail_v;
      push.lead.fixup_status = status_in;
      push.tail.fixed_byte   = tail_b;
      push.tail.record_done  = final_byte;
      push.tail.fixup_status = status_in;

      pos_in     = in_range ? pos_ff + POS_W'(1) : pos_ff;
      sec_pos_in = sec_pos_ff;
      sec_idx_in = sec_idx_ff;
      if (in_range) begin
         if (sec_pos_ff == SPOS_W'(SECTOR_BYTES - 1)) begin
            sec_pos_in = '0;
            sec_idx_in = sec_idx_ff + IDX_W'(1);
         end else begin
            sec_pos_in = sec_pos_ff + SPOS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         sec_pos_ff <= '0;
         sec_idx_ff <= '0;
         off_ff     <= '0;
         cnt_ff     <= '0;
         seq_ff     <= '0;
         hold_ff    <= 1'b0;
         status_ff  <= STATUS_OK;
         stopped_ff <= 1'b0;
         hdr_ok_ff  <= 1'b0;
      end else if (take) begin
         if (final_byte) begin
            pos_ff     <= '0;
            sec_pos_ff <= '0;
            sec_idx_ff <= '0;
            off_ff     <= '0;
            cnt_ff     <= '0;
            seq_ff     <= '0;
            hold_ff    <= 1'b0;
            status_ff  <= STATUS_OK;
            stopped_ff <= 1'b0;
            hdr_ok_ff  <= 1'b0;
         end else begin
            pos_ff     <= pos_in;
            sec_pos_ff <= sec_pos_in;
            sec_idx_ff <= sec_idx_in;
            off_ff     <= off_in;
            cnt_ff     <= cnt_in;
            seq_ff     <= seq_in;
            hold_ff    <= hold_in;
            status_ff  <= status_in;
            stopped_ff <= stopped_in;
            hdr_ok_ff  <= hdr_ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         held_ff <= held_in;
         repl_ff <= repl_in;
      end
   end

endmodule

// ----- sv/record_fixup_applier.sv -----
// a result is registered in the result queue before it is offered; the first byte of a
// sector-end pair waits for its partner and enters the queue together with it
// throughput: one byte per cycle while the queue has room, set by the single-pass fixup
// logic feeding a four-entry result queue that takes up to two results per cycle
// synchronous active-high reset clears record state, the queue, and restores the
// header field positions to 4 and 6
module record_fixup_applier
   import rfa_pkg::*;
#(
   parameter int RECORD_BYTES = 1024,
   parameter int SECTOR_BYTES = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_record_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_fixed_byte,
   output logic       rsp_record_done,
   output logic [2:0] rsp_fixup_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [5:0] csr_wdata
);

   logic [5:0]     offset_pos_ff;
   logic [5:0]     count_pos_ff;
   logic           space;
   logic           take;
   rfa_push_type   push;
   rfa_result_type rsp_item;

   assign csr_ready        = 1'b1;
   assign req_ready        = space;
   assign take             = req_valid && space;
   assign rsp_fixed_byte   = rsp_item.fixed_byte;
   assign rsp_record_done  = rsp_item.record_done;
   assign rsp_fixup_status = rsp_item.fixup_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_pos_ff <= 6'd4;
         count_pos_ff  <= 6'd6;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OFFSET_POS: offset_pos_ff <= csr_wdata;
            CSR_COUNT_POS:  count_pos_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   rfa_fixup_core #(
      .RECORD_BYTES (RECORD_BYTES),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .record_byte (req_record_byte),
      .final_byte  (req_final_byte),
      .offset_pos  (offset_pos_ff),
      .count_pos   (count_pos_ff),
      .push        (push)
   );

   rfa_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- tb/tb.sv -----
module tb;
   import rfa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RECORD_BYTES = 1024;
   localparam int SECTOR_BYTES = 512;
   localparam int SECTOR_SLOTS = RECORD_BYTES / SECTOR_BYTES + 1;
   localparam int MAX_LEN = 1100;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_ITEMS = 16;
   localparam int SHORT_MAX = 66;

   typedef enum {REC_FULL, REC_SHORT, REC_LONG, REC_BROKEN, REC_NOISE} rec_shape_type;

   typedef struct packed {
      logic [7:0]     b;
      logic           fin;
      logic           typed;
      rfa_result_type want;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [19] = '{
      '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, STATUS_SHORT}},
      '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, STATUS_SHORT}},
      '{8'h11, 1'b0, 1'b1, '{8'h11, 1'b0, STATUS_OK}},
      '{8'h22, 1'b0, 1'b1, '{8'h22, 1'b0, STATUS_OK}},
      '{8'h33, 1'b0, 1'b1, '{8'h33, 1'b0, STATUS_OK}},
      '{8'h44, 1'b0, 1'b1, '{8'h44, 1'b0, STATUS_OK}},
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, STATUS_OK}},
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, STATUS_OK}},
      '{8'h01, 1'b0, 1'b1, '{8'h01, 1'b0, STATUS_OK}},
      '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, STATUS_BAD_HDR}},
      '{8'hA5, 1'b0, 1'b0, '0},
      '{8'h5A, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h30, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h80, 1'b1, 1'b0, '0}
   };

   localparam logic [5:0] PHASE_OFFSET_POS [6] = '{6'd4, 6'd0, 6'd63, 6'd30, 6'd0, 6'd61};
   localparam logic [5:0] PHASE_COUNT_POS [6]  = '{6'd6, 6'd2, 6'd61, 6'd0, 6'd0, 6'd63};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_record_byte = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_fixed_byte;
   logic       rsp_record_done;
   logic [2:0] rsp_fixup_status;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_OFFSET_POS;
   logic [5:0] csr_wdata = 6'd0;

   record_fixup_applier dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_record_byte(req_record_byte),
      .req_final_byte(req_final_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_fixed_byte(rsp_fixed_byte),
      .rsp_record_done(rsp_record_done),
      .rsp_fixup_status(rsp_fixup_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   // fixup state as the block should hold it
   int          off_pos = 4;
   int          cnt_pos = 6;
   int          rec_pos;
   logic [15:0] arr_off;
   logic [15:0] arr_cnt;
   logic [15:0] seq_word;
   logic [15:0] repl_words [2];
   logic [7:0]  held_byte;
   bit          holding;
   logic [2:0]  rec_status;
   bit          stopped;
   bit          hdr_ok;

   rfa_result_type pending_fixed [$];
   int             fault_count = 0;
   bit             calm = 1'b0;
   int             squeeze_asked = 0;
   int             squeeze_done = 0;
   int             stall_left = 0;

   logic [7:0] rec_buf [MAX_LEN];
   int         rec_len;

   task automatic clear_record();
      rec_pos = 0;
      arr_off = '0;
      arr_cnt = '0;
      seq_word = '0;
      repl_words[0] = '0;
      repl_words[1] = '0;
      held_byte = '0;
      holding = 1'b0;
      rec_status = STATUS_OK;
      stopped = 1'b0;
      hdr_ok = 1'b0;
   endtask

   task automatic note_status(input logic [2:0] code);
      if (rec_status == STATUS_OK)
         rec_status = code;
   endtask

   task automatic predict_fixup(input logic [7:0] b, input logic fin, input bit keep);
      int             p;
      int             hl;
      int             rel;
      int             w;
      int             i;
      int             n;
      logic [15:0]    pair;
      logic [7:0]     outb [2];
      rfa_result_type r;
      p = rec_pos;
      n = 0;
      if (p < RECORD_BYTES) begin
         hl = (off_pos > cnt_pos ? off_pos : cnt_pos) + 1;
         if (p == off_pos) arr_off[7:0] = b;
         if (p == off_pos + 1) arr_off[15:8] = b;
         if (p == cnt_pos) arr_cnt[7:0] = b;
         if (p == cnt_pos + 1) arr_cnt[15:8] = b;
         if (p == hl && !hdr_ok && rec_status == STATUS_OK) begin
            if (arr_off >= MIN_ARRAY_OFFSET && int'(arr_off) < RECORD_BYTES && arr_cnt != 0 &&
                int'(arr_off) + 2 * int'(arr_cnt) <= RECORD_BYTES && int'(arr_off) > hl) begin
               hdr_ok = 1'b1;
            end else begin
               note_status(STATUS_BAD_HDR);
               stopped = 1'b1;
            end
         end
         if (hdr_ok && p >= int'(arr_off)) begin
            rel = p - int'(arr_off);
            w = rel >> 1;
            if (w < int'(arr_cnt)) begin
               if (w == 0) begin
                  if (rel[0]) seq_word[15:8] = b;
                  else seq_word[7:0] = b;
               end else if (w < SECTOR_SLOTS) begin
                  if (rel[0]) repl_words[w-1][15:8] = b;
                  else repl_words[w-1][7:0] = b;
               end
            end
         end
         if (holding) begin
            i = (p + 1) / SECTOR_BYTES;
            pair = {b, held_byte};
            holding = 1'b0;
            if (pair == seq_word && i >= 1 && i < SECTOR_SLOTS) begin
               outb[0] = repl_words[i-1][7:0];
               outb[1] = repl_words[i-1][15:8];
            end else begin
               note_status(STATUS_MISMATCH);
               stopped = 1'b1;
               outb[0] = held_byte;
               outb[1] = b;
            end
            n = 2;
         end else if (hdr_ok && !stopped && !fin && (p + 2) % SECTOR_BYTES == 0) begin
            i = (p + 2) / SECTOR_BYTES;
            if (i >= 1 && i < int'(arr_cnt)) begin
               if (int'(arr_off) + 2 * i + 1 < p) begin
                  held_byte = b;
                  holding = 1'b1;
                  rec_pos = p + 1;
                  return;
               end
               note_status(STATUS_PAST_END);
               stopped = 1'b1;
            end
            outb[0] = b;
            n = 1;
         end else begin
            outb[0] = b;
            n = 1;
         end
      end else begin
         outb[0] = b;
         n = 1;
      end
      if (fin && rec_status == STATUS_OK) begin
         if (p + 1 < RECORD_BYTES) rec_status = STATUS_SHORT;
         else if (!hdr_ok) rec_status = STATUS_BAD_HDR;
      end
      if (keep) begin
         for (int k = 0; k < n; k++) begin
            r.fixed_byte = outb[k];
            r.record_done = fin && (k == n - 1);
            r.fixup_status = rec_status;
            pending_fixed = {pending_fixed, r};
         end
      end
      if (fin) clear_record();
      else rec_pos = (p < RECORD_BYTES) ? p + 1 : RECORD_BYTES;
   endtask

   task automatic offer_byte(input logic [7:0] b, input logic fin);
      if (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_record_byte <= b;
      req_final_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [5:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_OFFSET_POS) off_pos = val;
      else cnt_pos = val;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_fixed.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic build_record(input rec_shape_type shape);
      int          hl;
      int          lo;
      int          off;
      int          cnt;
      logic [15:0] seq;
      for (int k = 0; k < MAX_LEN; k++) rec_buf[k] = 8'($urandom);
      rec_len = RECORD_BYTES;
      if (shape == REC_NOISE) begin
         rec_len = $urandom_range(1) ? $urandom_range(1, 100) : $urandom_range(1, MAX_LEN);
         return;
      end
      hl = (off_pos > cnt_pos ? off_pos : cnt_pos) + 1;
      lo = (hl + 1 > 42) ? hl + 1 : 42;
      off = ($urandom_range(4) == 0) ? $urandom_range(lo, 520) : $urandom_range(lo, 440);
      cnt = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 3;
      seq = 16'($urandom);
      rec_buf[off] = seq[7:0];
      rec_buf[off+1] = seq[15:8];
      for (int s = 1; s <= 2; s++) begin
         if ($urandom_range(5) != 0) begin
            rec_buf[s*SECTOR_BYTES-2] = seq[7:0];
            rec_buf[s*SECTOR_BYTES-1] = seq[15:8];
         end
      end
      if (shape == REC_BROKEN) begin
         case ($urandom_range(3))
            0: off = $urandom_range(0, lo - 1);
            1: cnt = 0;
            2: off = $urandom_range(RECORD_BYTES, 65535);
            default: cnt = $urandom_range((RECORD_BYTES - off) / 2 + 1, 65535);
         endcase
      end
      rec_buf[off_pos] = off[7:0];
      rec_buf[off_pos+1] = off[15:8];
      rec_buf[cnt_pos] = cnt[7:0];
      rec_buf[cnt_pos+1] = cnt[15:8];
      case (shape)
         REC_SHORT: begin
            case ($urandom_range(2))
               0: rec_len = $urandom_range(1, 80);
               1: rec_len = $urandom_range(509, 513);
               default: rec_len = $urandom_range(81, RECORD_BYTES - 1);
            endcase
         end
         REC_LONG: rec_len = RECORD_BYTES + $urandom_range(1, 6);
         default: rec_len = RECORD_BYTES;
      endcase
   endtask

   task automatic send_bytes(input int first, input int last);
      for (int k = first; k < last; k++) begin
         predict_fixup(rec_buf[k], k == rec_len - 1, 1'b1);
         offer_byte(rec_buf[k], k == rec_len - 1);
      end
   endtask

   // result check and receiver stalls
   always @(posedge clock) begin
      rfa_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_fixed.size() == 0) begin
               $error("unexpected result: fixed_byte %0h", rsp_fixed_byte);
               fault_count++;
            end else begin
               want = pending_fixed.pop_front();
               if (rsp_fixed_byte !== want.fixed_byte) begin
                  $error("fixed_byte: expected %0h, got %0h", want.fixed_byte, rsp_fixed_byte);
                  fault_count++;
               end
               if (rsp_record_done !== want.record_done) begin
                  $error("record_done: expected %0d, got %0d", want.record_done,
                         rsp_record_done);
                  fault_count++;
               end
               if (rsp_fixup_status !== want.fixup_status) begin
                  $error("fixup_status: expected %0d, got %0d", want.fixup_status,
                         rsp_fixup_status);
                  fault_count++;
               end
            end
         end
         if (squeeze_done != squeeze_asked) begin
            squeeze_done = squeeze_asked;
            stall_left = HOLD_OFF_CYCLES;
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && (calm || $urandom_range(99) >= 15);
      end
   end

   initial begin
      int            phase_items;
      int            pick;
      rec_shape_type shape;
      clear_record();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[k]) begin
         predict_fixup(DIRECTED_ROWS[k].b, DIRECTED_ROWS[k].fin, !DIRECTED_ROWS[k].typed);
         if (DIRECTED_ROWS[k].typed) pending_fixed = {pending_fixed, DIRECTED_ROWS[k].want};
         offer_byte(DIRECTED_ROWS[k].b, DIRECTED_ROWS[k].fin);
      end

      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            drain();
            write_csr(CSR_OFFSET_POS, PHASE_OFFSET_POS[ph]);
            write_csr(CSR_COUNT_POS, PHASE_COUNT_POS[ph]);
         end
         if (ph == 1) squeeze_asked++;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 50) shape = REC_FULL;
            else if (pick < 65) shape = REC_SHORT;
            else if (pick < 72) shape = REC_LONG;
            else if (pick < 85) shape = REC_BROKEN;
            else shape = REC_NOISE;
            // opening record runs past the first sector end with no idling
            calm = (ph == 0 && phase_items == 0);
            if (calm) shape = REC_FULL;
            build_record(shape);
            if (calm) rec_len = $urandom_range(SECTOR_BYTES + 1, SECTOR_BYTES + 8);
            else if (rec_len > SHORT_MAX) rec_len = $urandom_range(2, SHORT_MAX);
            send_bytes(0, rec_len);
            calm = 1'b0;
            phase_items += rec_len;
         end
      end

      // positions move behind the current byte so the header check never happens
      drain();
      write_csr(CSR_OFFSET_POS, 6'd20);
      write_csr(CSR_COUNT_POS, 6'd30);
      build_record(REC_FULL);
      rec_len = 40;
      send_bytes(0, 10);
      drain();
      write_csr(CSR_OFFSET_POS, 6'd0);
      write_csr(CSR_COUNT_POS, 6'd2);
      send_bytes(10, rec_len);

      drain();
      repeat (10) @(posedge clock);
      if (fault_count == 0 && pending_fixed.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
